### design/assert_macros.svh
// Assertion macros shared by the scanner RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked only while reset is low.
`define ASSERT_CLKD(name, clock, reset, prop) \
  name: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("assertion failed");
// Checked at every edge, during reset too.
`define ASSERT_ALWAYS(name, clock, prop) \
  name: assert property (@(posedge clock) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLKD(name, clock, reset, prop)
`define ASSERT_ALWAYS(name, clock, prop)
`endif

`endif

### design/mss_pkg.sv
// Types and constants of the masked signature scanner.
// No dependencies; used by the interfaces and all modules.
package mss_pkg;

  localparam int PATTERN_BYTES = 19;
  localparam int PATTERN_W     = PATTERN_BYTES * 8;
  // Extraction reads off+0..off+3 with a 4-bit offset: 5 index bits suffice.
  localparam int SPAN_IDX_W    = 5;
  localparam int SPAN_BYTES    = 1 << SPAN_IDX_W;
  localparam int OFFSET_W      = 4;
  localparam int TAIL_COUNT_W  = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_INDEX_W   = 3;

  typedef logic [7:0]  byte_t;
  typedef logic [31:0] seed_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_LOW   = 3'd0,
    REG_PATTERN_MID   = 3'd1,
    REG_PATTERN_HIGH  = 3'd2,
    REG_CARE_MASK     = 3'd3,
    REG_FIRST_OFFSET  = 3'd4,
    REG_SECOND_OFFSET = 3'd5
  } reg_index_t;

  localparam logic [63:0]            PATTERN_LOW_RST   = 64'h0035_0000_0000_0081;
  localparam logic [63:0]            PATTERN_MID_RST   = 64'h0;
  localparam logic [23:0]            PATTERN_HIGH_RST  = 24'h086A00;
  localparam logic [PATTERN_BYTES-1:0] CARE_MASK_RST   = 19'h60041;
  localparam logic [OFFSET_W-1:0]    FIRST_OFFSET_RST  = 4'd2;
  localparam logic [OFFSET_W-1:0]    SECOND_OFFSET_RST = 4'd7;

  typedef struct packed {
    logic  hit;
    seed_t first_word;
    seed_t second_word;
  } match_result_t;

endpackage

### design/mss_in_if.sv
// Input channel of the scanner: one stream byte per word.
// Depends on mss_pkg.
interface mss_in_if;
  import mss_pkg::*;

  logic  valid;
  logic  ready;
  byte_t data_byte;
  logic  last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### design/mss_out_if.sv
// Result channel of the scanner: found flag and two extracted seeds.
// Depends on mss_pkg.
interface mss_out_if;
  import mss_pkg::*;

  logic  valid;
  logic  ready;
  logic  found;
  seed_t first_seed;
  seed_t second_seed;

  modport source (output valid, output found, output first_seed, output second_seed,
                  input ready);
  modport sink   (input valid, input found, input first_seed, input second_seed,
                  output ready);
endinterface

### design/mss_match.sv
// Masked window compare and little-endian word extraction.
// Purely combinational; depends on mss_pkg.
module mss_match #(
  parameter int WINDOW_BYTES = 19
) (
  input  logic [WINDOW_BYTES-1:0][7:0]             window,
  input  logic [mss_pkg::PATTERN_W-1:0]            pattern,
  input  logic [mss_pkg::PATTERN_BYTES-1:0]        care_mask,
  input  logic [mss_pkg::OFFSET_W-1:0]             first_offset,
  input  logic [mss_pkg::OFFSET_W-1:0]             second_offset,
  output mss_pkg::match_result_t                   result
);
  import mss_pkg::*;

  logic [PATTERN_BYTES-1:0]    miss;
  logic [SPAN_BYTES-1:0][7:0]  span;

  // Pattern bytes past the end of the window are never compared, and
  // extraction bytes past the window read as zero.
  for (genvar j = 0; j < PATTERN_BYTES; j++) begin : g_cmp
    if (j < WINDOW_BYTES) begin : g_in
      assign miss[j] = care_mask[j] && (window[j] != pattern[8*j +: 8]);
    end else begin : g_out
      assign miss[j] = 1'b0;
    end
  end

  for (genvar i = 0; i < SPAN_BYTES; i++) begin : g_span
    if (i < WINDOW_BYTES) begin : g_in
      assign span[i] = window[i];
    end else begin : g_out
      assign span[i] = '0;
    end
  end

  function automatic seed_t extract(input logic [OFFSET_W-1:0] off,
                                    input logic [SPAN_BYTES-1:0][7:0] src);
    seed_t w;
    logic [SPAN_IDX_W-1:0] idx;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      idx = SPAN_IDX_W'(off) + SPAN_IDX_W'(k);
      w[8*k +: 8] = src[idx];
    end
    return w;
  endfunction

  assign result.hit         = ~|miss;
  assign result.first_word  = extract(first_offset, span);
  assign result.second_word = extract(second_offset, span);
endmodule

### design/masked_signature_scan_extract_core.sv
// Masked signature scanner: finds the first window matching a masked byte
// pattern and reports two 32-bit words read from it.
// Depends on mss_pkg, mss_in_if, mss_out_if, mss_match and assert_macros.svh.
// Usage:
//   scan_in carries the stream one byte per word, with last_byte on the final
//   byte. result_out carries at most one word per stream: found=1 with both
//   seeds once the first matching window has TAIL_GUARD bytes after it, or
//   found=0 with zero seeds on the last byte when no such match occurred.
//   Configuration writes use cfg_write/cfg_index/cfg_data, one register per cycle,
//   by the user only while the block is idle (unenforced); unknown indexes ignored.
// Timing:
//   One byte is accepted every cycle while scan_in.ready is high. The compare
//   and extraction run on the shifted window in the accepting cycle, and the
//   result sits in the output register in the cycle after the byte causing it.
//   When result_out stalls, scan_in.ready drops only while the output
//   register is full and not being taken.
// Reset:
//   rst (synchronous) empties the output register, clears the scan state and
//   restores default pattern, mask and offsets. Each last byte clears the
//   scan state too; configuration is kept.
`include "assert_macros.svh"

module masked_signature_scan_extract_core #(
  parameter int WINDOW_BYTES = 19,
  parameter int TAIL_GUARD   = 10
) (
  input  logic                              clk,
  input  logic                              rst,
  mss_in_if.sink                            scan_in,
  mss_out_if.source                         result_out,
  input  logic                              cfg_write,
  input  logic [mss_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mss_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mss_pkg::*;

  localparam int SEEN_W = $clog2(WINDOW_BYTES + 1);
  localparam logic [SEEN_W-1:0]       SEEN_FULL = SEEN_W'(WINDOW_BYTES);
  localparam logic [TAIL_COUNT_W-1:0] GUARD     = TAIL_COUNT_W'(TAIL_GUARD);

  // Configuration registers.
  logic [63:0]              pattern_low;
  logic [63:0]              pattern_mid;
  logic [23:0]              pattern_high;
  logic [PATTERN_BYTES-1:0] care_mask;
  logic [OFFSET_W-1:0]      first_offset;
  logic [OFFSET_W-1:0]      second_offset;

  // Scan state.
  logic [WINDOW_BYTES-1:0][7:0] window, window_next;
  logic [SEEN_W-1:0]            bytes_seen, bytes_seen_next;
  logic                         candidate_held, candidate_held_next;
  logic [TAIL_COUNT_W-1:0]      tail_count, tail_count_next;
  seed_t                        held_first, held_first_next;
  seed_t                        held_second, held_second_next;
  logic                         reported, reported_next;

  logic          accept;
  logic          emit;
  logic          emit_found;
  match_result_t match;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low   <= PATTERN_LOW_RST;
      pattern_mid   <= PATTERN_MID_RST;
      pattern_high  <= PATTERN_HIGH_RST;
      care_mask     <= CARE_MASK_RST;
      first_offset  <= FIRST_OFFSET_RST;
      second_offset <= SECOND_OFFSET_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:   pattern_low   <= cfg_data;
        REG_PATTERN_MID:   pattern_mid   <= cfg_data;
        REG_PATTERN_HIGH:  pattern_high  <= cfg_data[23:0];
        REG_CARE_MASK:     care_mask     <= cfg_data[PATTERN_BYTES-1:0];
        REG_FIRST_OFFSET:  first_offset  <= cfg_data[OFFSET_W-1:0];
        REG_SECOND_OFFSET: second_offset <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  assign accept        = scan_in.valid && scan_in.ready;
  assign scan_in.ready = !result_out.valid || result_out.ready;

  // Oldest byte at index 0; the new byte enters at the top.
  assign window_next = {scan_in.data_byte, window[WINDOW_BYTES-1:1]};

  mss_match #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_match (
    .window        (window_next),
    .pattern       ({pattern_high, pattern_mid, pattern_low}),
    .care_mask     (care_mask),
    .first_offset  (first_offset),
    .second_offset (second_offset),
    .result        (match)
  );

  always_comb begin
    bytes_seen_next     = (bytes_seen < SEEN_FULL) ? bytes_seen + 1'b1 : bytes_seen;
    candidate_held_next = candidate_held;
    tail_count_next     = tail_count;
    held_first_next     = held_first;
    held_second_next    = held_second;
    reported_next       = reported;
    if (!reported) begin
      if (candidate_held) begin
        tail_count_next = tail_count + 1'b1;
        if (tail_count_next >= GUARD) begin
          reported_next = 1'b1;
        end
      end else if (bytes_seen_next == SEEN_FULL && match.hit) begin
        candidate_held_next = 1'b1;
        tail_count_next     = '0;
        held_first_next     = match.first_word;
        held_second_next    = match.second_word;
        if (TAIL_GUARD == 0) begin
          reported_next = 1'b1;
        end
      end
    end
    // A match report on the last byte takes precedence over not-found.
    emit_found = reported_next && !reported;
    emit       = emit_found || (scan_in.last_byte && !reported_next);
    if (scan_in.last_byte) begin
      bytes_seen_next     = '0;
      candidate_held_next = 1'b0;
      tail_count_next     = '0;
      reported_next       = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      candidate_held <= 1'b0;
      tail_count     <= '0;
      reported       <= 1'b0;
    end else if (accept) begin
      bytes_seen     <= bytes_seen_next;
      candidate_held <= candidate_held_next;
      tail_count     <= tail_count_next;
      reported       <= reported_next;
    end
  end

  // Window contents and held words only matter once qualified by the counters.
  always_ff @(posedge clk) begin
    if (accept) begin
      window      <= window_next;
      held_first  <= held_first_next;
      held_second <= held_second_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (accept && emit) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      result_out.found       <= emit_found;
      result_out.first_seed  <= emit_found ? held_first_next  : '0;
      result_out.second_seed <= emit_found ? held_second_next : '0;
    end
  end

  `ASSERT_CLKD(a_report_needs_candidate, clk, rst, reported |-> candidate_held)
  `ASSERT_CLKD(a_tail_below_guard, clk, rst,
               (candidate_held && !reported) |-> (tail_count < GUARD))
  `ASSERT_CLKD(a_last_clears_state, clk, rst,
               (accept && scan_in.last_byte) |=>
               (bytes_seen == '0 && !candidate_held && !reported))
  `ASSERT_CLKD(a_no_accept_when_full, clk, rst,
               (result_out.valid && !result_out.ready) |-> !scan_in.ready)
  `ASSERT_ALWAYS(a_reset_empties_output, clk, rst |=> !result_out.valid)
endmodule
